// File: hdl/iqmpd_pkg.sv
// ----------------------------------------------------------------------------
// iqmpd_pkg
// Shared types and constants of the I/Q magnitude and power detector.
// ----------------------------------------------------------------------------
package iqmpd_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int OFFSET_W   = 13;
  localparam int SCALE_W    = 16;
  localparam int LEVEL_W    = 8;
  localparam int COUNT_W    = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_POWER_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DC_OFFSET_I  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DC_OFFSET_Q  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SCALE = 2'd3;

  localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RESET = 16'd4096;

  localparam int MAG_W      = 13;
  localparam int SQUARE_W   = 2 * MAG_W;
  localparam int POWER_W    = SQUARE_W + 2;
  localparam int RADICAND_W = 36;
  localparam int ROOT_W     = RADICAND_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int PROD_W     = POWER_W + SCALE_W;
  localparam int FRAC_SHIFT = 20;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [PROD_W-1:0]  CLIP_LIMIT = PROD_W'(255) << FRAC_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_i;
    logic [SAMPLE_W-1:0] sample_q;
  } sample_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               overflow;
    logic [COUNT_W-1:0] overflow_total;
  } level_word_t;

  typedef struct packed {
    logic                power_mode;
    logic [OFFSET_W-1:0] dc_offset_i;
    logic [OFFSET_W-1:0] dc_offset_q;
    logic [SCALE_W-1:0]  output_scale;
  } cfg_t;

  typedef struct packed {
    logic               push;
    logic [POWER_W-1:0] power;
  } queue_in_t;

  typedef struct packed {
    logic               empty;
    logic [POWER_W-1:0] power;
  } queue_out_t;

endpackage

// File: hdl/iqmpd_front.sv
// ----------------------------------------------------------------------------
// iqmpd_front
// Accepts sample words, removes DC offsets, squares and sums both channels,
// and pushes the power into the queue.
// ----------------------------------------------------------------------------
module iqmpd_front import iqmpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  sample_word_t in_data,
  output queue_in_t    q_in,
  input  logic         q_full
);

  logic             adv;
  logic             a_valid;
  logic [MAG_W-1:0] abs_i;
  logic [MAG_W-1:0] abs_q;
  logic             b_valid;
  logic [SQUARE_W-1:0] sq_i;
  logic [SQUARE_W-1:0] sq_q;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] s,
                                                input logic [OFFSET_W-1:0] off);
    logic signed [OFFSET_W+1:0] d;
    d = $signed({2'b00, s, 4'b0000}) - $signed({{2{off[OFFSET_W-1]}}, off});
    return d[OFFSET_W+1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  assign adv      = !(b_valid && q_full);
  assign in_ready = adv;

  assign q_in.push  = b_valid && !q_full;
  assign q_in.power = POWER_W'(sq_i) + POWER_W'(sq_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abs_i <= abs_diff(in_data.sample_i, cfg.dc_offset_i);
      abs_q <= abs_diff(in_data.sample_q, cfg.dc_offset_q);
      sq_i  <= SQUARE_W'(abs_i) * SQUARE_W'(abs_i);
      sq_q  <= SQUARE_W'(abs_q) * SQUARE_W'(abs_q);
    end
  end

endmodule

// File: hdl/iqmpd_fifo.sv
// ----------------------------------------------------------------------------
// iqmpd_fifo
// Short queue of power words between the front and back parts.
// ----------------------------------------------------------------------------
module iqmpd_fifo import iqmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  queue_in_t  q_in,
  output logic       q_full,
  input  logic       pop,
  output queue_out_t q_out
);

  logic [POWER_W-1:0]  mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_pop;

  assign q_full      = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign q_out.empty = (count == '0);
  assign q_out.power = mem[rptr];
  assign do_pop      = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (q_in.push) begin
        wptr <= (wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + QUEUE_AW'(1);
      end
      case ({q_in.push, do_pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_in.push) begin
      mem[wptr] <= q_in.power;
    end
  end

endmodule

// File: hdl/iqmpd_back.sv
// ----------------------------------------------------------------------------
// iqmpd_back
// Pipelined square root (one root bit per stage), scale multiply, clipping,
// clip counter and output register.
// ----------------------------------------------------------------------------
module iqmpd_back import iqmpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  queue_out_t  q_out,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output level_word_t out_data
);

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
    logic [RADICAND_W-1:0] rad;
    logic [POWER_W-1:0]    power;
  } sqrt_state_t;

  logic               adv;
  logic               st_valid [ROOT_W];
  sqrt_state_t        st       [ROOT_W];
  sqrt_state_t        st_next  [ROOT_W];
  sqrt_state_t        st_init;
  logic [POWER_W-1:0] base;
  logic               m_valid;
  logic [PROD_W-1:0]  prod;
  logic               clip;
  logic [COUNT_W-1:0] clip_count;
  logic [COUNT_W-1:0] clip_count_next;

  function automatic sqrt_state_t sqrt_step(input sqrt_state_t c);
    sqrt_state_t      n;
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    n       = c;
    shifted = {c.rem, c.rad[RADICAND_W-1 -: 2]};
    trial   = (REM_W + 2)'({c.root, 2'b01});
    n.rad   = c.rad << 2;
    if (shifted >= trial) begin
      n.rem  = REM_W'(shifted - trial);
      n.root = {c.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = REM_W'(shifted);
      n.root = {c.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_out.empty;

  always_comb begin
    st_init.rem   = '0;
    st_init.root  = '0;
    st_init.rad   = {q_out.power, {(RADICAND_W - POWER_W){1'b0}}};
    st_init.power = q_out.power;
  end

  always_comb begin
    st_next[0] = sqrt_step(st_init);
    for (int s = 1; s < ROOT_W; s++) begin
      st_next[s] = sqrt_step(st[s-1]);
    end
  end

  assign base = cfg.power_mode ? st[ROOT_W-1].power : POWER_W'(st[ROOT_W-1].root);

  assign clip            = (prod > CLIP_LIMIT);
  assign clip_count_next = (clip && (clip_count != '1)) ? clip_count + COUNT_W'(1)
                                                        : clip_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ROOT_W; s++) begin
        st_valid[s] <= 1'b0;
      end
      m_valid    <= 1'b0;
      out_valid  <= 1'b0;
      clip_count <= '0;
    end else if (adv) begin
      st_valid[0] <= !q_out.empty;
      for (int s = 1; s < ROOT_W; s++) begin
        st_valid[s] <= st_valid[s-1];
      end
      m_valid   <= st_valid[ROOT_W-1];
      out_valid <= m_valid;
      if (m_valid) begin
        clip_count <= clip_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < ROOT_W; s++) begin
        st[s] <= st_next[s];
      end
      prod                    <= PROD_W'(base) * PROD_W'(cfg.output_scale);
      out_data.level          <= clip ? LEVEL_MAX : prod[FRAC_SHIFT +: LEVEL_W];
      out_data.overflow       <= clip;
      out_data.overflow_total <= clip_count_next;
    end
  end

endmodule

// File: hdl/iq_magnitude_power_detector.sv
// ----------------------------------------------------------------------------
// iq_magnitude_power_detector
// Offset-corrected I/Q power or magnitude, scaled, clipped to 8 bits, with a
// saturating clip counter.
//
//   channel   dir   handshake             word
//   in        in    in_valid / in_ready    sample_word_t (sample_i, sample_q)
//   out       out   out_valid / out_ready  level_word_t (level, overflow, total)
//   cfg       in    cfg_we                 cfg_index, cfg_data
//
// One word per cycle when out_ready stays high; after the accepting edge a word
// passes the second front stage, the queue, 18 square-root stages (one root
// bit each), the multiply stage and the output register before out_valid rises.
// Reset is synchronous and clears all valid bits, the queue and the counter.
// A stalled output freezes the back pipeline; the queue lets the front keep
// accepting until it fills.
// ----------------------------------------------------------------------------
module iq_magnitude_power_detector import iqmpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sample_word_t           in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output level_word_t            out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  queue_in_t  q_in;
  queue_out_t q_out;
  logic       q_full;
  logic       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_mode   <= 1'b0;
      cfg.dc_offset_i  <= '0;
      cfg.dc_offset_q  <= '0;
      cfg.output_scale <= OUTPUT_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POWER_MODE:   cfg.power_mode   <= cfg_data[0];
        REG_DC_OFFSET_I:  cfg.dc_offset_i  <= cfg_data[OFFSET_W-1:0];
        REG_DC_OFFSET_Q:  cfg.dc_offset_q  <= cfg_data[OFFSET_W-1:0];
        REG_OUTPUT_SCALE: cfg.output_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  iqmpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_in     (q_in),
    .q_full   (q_full)
  );

  iqmpd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_in),
    .q_full (q_full),
    .pop    (pop),
    .q_out  (q_out)
  );

  iqmpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_out     (q_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/iqmpd_checker.sv
// ----------------------------------------------------------------------------
// iqmpd_checker
// Port-level checks of the detector's output words and clip count.
// ----------------------------------------------------------------------------
module iqmpd_checker import iqmpd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input level_word_t out_data
);

  logic [COUNT_W-1:0] last_total;
  logic               out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (out_fire) begin
      last_total <= out_data.overflow_total;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_clip_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |-> out_data.level == LEVEL_MAX)
    else $error("clipped word without full-scale level");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    out_fire && !out_data.overflow |-> out_data.overflow_total == last_total)
    else $error("clip count moved without a clip");

  a_total_bump: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_data.overflow |->
      (out_data.overflow_total == last_total + COUNT_W'(1)) ||
      ((last_total == '1) && (out_data.overflow_total == '1)))
    else $error("clip count did not advance on a clip");

endmodule

bind iq_magnitude_power_detector iqmpd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
